// ----- design/gpsph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gpsph_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COMMAND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_COMMAND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_CODE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CODE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_CODE       = 3'd6;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_ACKH,
		PH_LOW,
		PH_HIGH,
		PH_ACKL
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_DIGITAL,
		KIND_GREEN,
		KIND_RED
	} kind_t;

	// position in the upper button byte for each bit of the second data byte
	localparam logic [2:0] STD_MAP [8] = '{3'd5, 3'd4, 3'd7, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [2:0] GREEN_MAP [8] = '{3'd7, 3'd6, 3'd3, 3'd0, 3'd4, 3'd1, 3'd2, 3'd5};

	function automatic logic [7:0] upper_buttons(input logic [7:0] d1, input logic green);
		logic [7:0] r;
		logic [2:0] p;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			p = green ? GREEN_MAP[i] : STD_MAP[i];
			if (!d1[i]) begin
				r[p] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/gpsph_tick_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gpsph_tick_if;
	logic valid;
	logic ready;
	logic scan_request;
	logic data_pin;
	logic ack_pin;

	modport source (output valid, output scan_request, output data_pin, output ack_pin,
		input ready);
	modport sink (input valid, input scan_request, input data_pin, input ack_pin,
		output ready);
endinterface

`default_nettype wire

// ----- design/gpsph_report_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gpsph_report_if;
	logic        valid;
	logic        ready;
	logic        clock_line;
	logic        command_line;
	logic        attention_line;
	logic        report_valid;
	logic        connected;
	logic [7:0]  pad_mode;
	logic [15:0] buttons;
	logic [7:0]  right_stick_x;
	logic [7:0]  right_stick_y;
	logic [7:0]  left_stick_x;
	logic [7:0]  left_stick_y;

	modport source (output valid, output clock_line, output command_line,
		output attention_line, output report_valid, output connected, output pad_mode,
		output buttons, output right_stick_x, output right_stick_y, output left_stick_x,
		output left_stick_y, input ready);
	modport sink (input valid, input clock_line, input command_line,
		input attention_line, input report_valid, input connected, input pad_mode,
		input buttons, input right_stick_x, input right_stick_y, input left_stick_x,
		input left_stick_y, output ready);
endinterface

`default_nettype wire

// ----- design/gpsph_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gpsph_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gpsph_pkg::CFG_IDX_W-1:0]  index;
	logic [gpsph_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/game_pad_serial_poll_host_core.sv -----
// The result of a tick request is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle while the report side is ready; the whole tick update is one pass of next-state logic
// between the state registers and the result flag register.
// A new tick is taken while the previous result is taken in the same cycle.
// Reset (arst_n low, asynchronous): idle, link down, reports zero, registers at defaults;
// the data byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module game_pad_serial_poll_host_core #(
	parameter int MAX_DATA_BYTES = 6,
	parameter int ANALOG_BYTES = 6,
	parameter int DIGITAL_BYTES = 2
) (
	input  wire            clk,
	input  wire            arst_n,
	gpsph_tick_if.sink     tick,
	gpsph_report_if.source report,
	gpsph_cfg_if.sink      cfg
);

	localparam int BPW = $clog2(MAX_DATA_BYTES + 4);
	localparam int BRW = $clog2(MAX_DATA_BYTES + 1);
	localparam int ANA_CNT = (ANALOG_BYTES > MAX_DATA_BYTES) ? MAX_DATA_BYTES : ANALOG_BYTES;
	localparam int DIG_CNT = (DIGITAL_BYTES > MAX_DATA_BYTES) ? MAX_DATA_BYTES : DIGITAL_BYTES;

	// configuration
	logic [15:0] half_q;
	logic [7:0]  ackto_q;
	logic [7:0]  start_q;
	logic [7:0]  poll_q;
	logic [7:0]  dig_code_q;
	logic [7:0]  green_code_q;
	logic [7:0]  red_code_q;

	// link state
	gpsph_pkg::phase_t phase_q, phase_n;
	gpsph_pkg::kind_t  kind_q, kind_n;
	logic [15:0]     tick_q, tick_n;
	logic [2:0]      bit_q, bit_n;
	logic [BPW-1:0]  bpos_q, bpos_n;
	logic [7:0]      shift_q, shift_n;
	logic [7:0]      mode_q, mode_n;
	logic [BRW-1:0]  brem_q, brem_n;
	logic            link_q, link_n;
	logic [15:0]     btn_q, btn_n;
	logic [7:0]      stick_q [4];
	logic [7:0]      stick_n [4];
	logic [7:0]      data_q [MAX_DATA_BYTES];
	logic [7:0]      data_rd [6];

	logic            out_valid_q;
	logic            rvalid_q, rvalid_n;
	logic            accept;
	logic            half_done;
	logic            ackl_done;
	logic [15:0]     tick_inc;
	logic            dec_req;
	logic            wr_en;
	logic [BPW-1:0]  wr_idx;
	logic [7:0]      cmd_byte;

	assign accept = tick.valid && tick.ready;
	assign tick.ready = !out_valid_q || report.ready;
	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q       <= 16'd80;
			ackto_q      <= 8'd100;
			start_q      <= 8'd1;
			poll_q       <= 8'd66;
			dig_code_q   <= 8'd65;
			green_code_q <= 8'd83;
			red_code_q   <= 8'd115;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gpsph_pkg::CFG_HALF_BIT_TICKS: half_q <= cfg.data;
				gpsph_pkg::CFG_ACK_TIMEOUT:    ackto_q <= cfg.data[7:0];
				gpsph_pkg::CFG_START_COMMAND:  start_q <= cfg.data[7:0];
				gpsph_pkg::CFG_POLL_COMMAND:   poll_q <= cfg.data[7:0];
				gpsph_pkg::CFG_DIGITAL_CODE:   dig_code_q <= cfg.data[7:0];
				gpsph_pkg::CFG_GREEN_CODE:     green_code_q <= cfg.data[7:0];
				gpsph_pkg::CFG_RED_CODE:       red_code_q <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// data bytes beyond the store read as zero
	genvar k;
	for (k = 0; k < 6; k++) begin : g_rd
		if (k < MAX_DATA_BYTES) begin : g_in
			assign data_rd[k] = data_q[k];
		end else begin : g_out
			assign data_rd[k] = 8'd0;
		end
	end

	// a zero half period behaves as one
	assign half_done = (({1'b0, tick_q} + 17'd1) >= {1'b0, half_q});
	assign ackl_done = !tick.ack_pin || (({1'b0, tick_q} + 17'd1) >= {9'd0, ackto_q});
	assign tick_inc = tick_q + 16'd1;
	assign wr_idx = bpos_q - BPW'(3);

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		bpos_n   = bpos_q;
		shift_n  = shift_q;
		mode_n   = mode_q;
		brem_n   = brem_q;
		link_n   = link_q;
		btn_n    = btn_q;
		stick_n  = stick_q;
		rvalid_n = 1'b0;
		dec_req  = 1'b0;
		wr_en    = 1'b0;

		unique case (phase_q)
			gpsph_pkg::PH_SETUP: begin
				if (half_done) begin
					phase_n = gpsph_pkg::PH_ACKH;
					tick_n = '0;
				end else begin
					tick_n = tick_inc;
				end
			end
			gpsph_pkg::PH_ACKH: begin
				if (tick.ack_pin) begin
					link_n = 1'b1;
					phase_n = gpsph_pkg::PH_LOW;
					tick_n = '0;
					bit_n = '0;
					shift_n = '0;
				end else begin
					tick_n = tick_inc;
					if (tick_inc > {8'd0, ackto_q}) begin
						link_n = 1'b0;
						rvalid_n = 1'b1;
						phase_n = gpsph_pkg::PH_IDLE;
						tick_n = '0;
					end
				end
			end
			gpsph_pkg::PH_LOW: begin
				if (half_done) begin
					if (tick.data_pin) begin
						shift_n[bit_q] = 1'b1;
					end
					phase_n = gpsph_pkg::PH_HIGH;
					tick_n = '0;
				end else begin
					tick_n = tick_inc;
				end
			end
			gpsph_pkg::PH_HIGH: begin
				if (half_done) begin
					tick_n = '0;
					if (bit_q != 3'd7) begin
						bit_n = bit_q + 3'd1;
						phase_n = gpsph_pkg::PH_LOW;
					end else begin
						// byte complete
						if (bpos_q != {BPW{1'b1}}) begin
							bpos_n = bpos_q + BPW'(1);
						end
						if (bpos_q == BPW'(0)) begin
							phase_n = gpsph_pkg::PH_ACKL;
						end else if (bpos_q == BPW'(1)) begin
							mode_n = shift_q;
							phase_n = gpsph_pkg::PH_ACKH;
						end else if (bpos_q == BPW'(2)) begin
							phase_n = gpsph_pkg::PH_ACKH;
							if (mode_q == dig_code_q) begin
								kind_n = gpsph_pkg::KIND_DIGITAL;
								brem_n = BRW'(DIG_CNT);
							end else if (mode_q == green_code_q) begin
								kind_n = gpsph_pkg::KIND_GREEN;
								brem_n = BRW'(ANA_CNT);
							end else if (mode_q == red_code_q) begin
								kind_n = gpsph_pkg::KIND_RED;
								brem_n = BRW'(ANA_CNT);
							end else begin
								// unknown mode: drop the link, no decode
								kind_n = gpsph_pkg::KIND_NONE;
								brem_n = '0;
								link_n = 1'b0;
								phase_n = gpsph_pkg::PH_IDLE;
								rvalid_n = 1'b1;
							end
							if (kind_n != gpsph_pkg::KIND_NONE && brem_n == '0) begin
								phase_n = gpsph_pkg::PH_IDLE;
								rvalid_n = 1'b1;
								dec_req = 1'b1;
							end
						end else begin
							wr_en = (wr_idx < BPW'(MAX_DATA_BYTES));
							if (brem_q != '0) begin
								brem_n = brem_q - BRW'(1);
							end
							phase_n = (brem_n == '0) ? gpsph_pkg::PH_ACKL : gpsph_pkg::PH_ACKH;
						end
					end
				end else begin
					tick_n = tick_inc;
				end
			end
			gpsph_pkg::PH_ACKL: begin
				if (ackl_done) begin
					tick_n = '0;
					if (bpos_q == BPW'(1)) begin
						phase_n = gpsph_pkg::PH_ACKH;
					end else begin
						phase_n = gpsph_pkg::PH_IDLE;
						rvalid_n = 1'b1;
						dec_req = 1'b1;
					end
				end else begin
					tick_n = tick_inc;
				end
			end
			default: begin
				phase_n = gpsph_pkg::PH_IDLE;
				if (tick.scan_request) begin
					phase_n = gpsph_pkg::PH_SETUP;
					tick_n = '0;
					bpos_n = '0;
					bit_n = '0;
					brem_n = '0;
				end
			end
		endcase

		if (dec_req && link_n && kind_n != gpsph_pkg::KIND_NONE) begin
			btn_n = {gpsph_pkg::upper_buttons(data_rd[1], kind_n == gpsph_pkg::KIND_GREEN),
				~data_rd[0]};
			if (kind_n == gpsph_pkg::KIND_GREEN || kind_n == gpsph_pkg::KIND_RED) begin
				for (int i = 0; i < 4; i++) begin
					stick_n[i] = data_rd[2+i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gpsph_pkg::PH_IDLE;
			kind_q   <= gpsph_pkg::KIND_NONE;
			tick_q   <= '0;
			bit_q    <= '0;
			bpos_q   <= '0;
			shift_q  <= '0;
			mode_q   <= '0;
			brem_q   <= '0;
			link_q   <= 1'b0;
			btn_q    <= '0;
			rvalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				stick_q[i] <= '0;
			end
		end else if (accept) begin
			phase_q  <= phase_n;
			kind_q   <= kind_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			bpos_q   <= bpos_n;
			shift_q  <= shift_n;
			mode_q   <= mode_n;
			brem_q   <= brem_n;
			link_q   <= link_n;
			btn_q    <= btn_n;
			rvalid_q <= rvalid_n;
			for (int i = 0; i < 4; i++) begin
				stick_q[i] <= stick_n[i];
			end
		end
	end

	// received data bytes, no reset
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				if (wr_idx == BPW'(i)) begin
					data_q[i] <= shift_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result fields come straight from the state registers, which hold while stalled
	always_comb begin
		case (bpos_q)
			BPW'(0): cmd_byte = start_q;
			BPW'(1): cmd_byte = poll_q;
			default: cmd_byte = 8'd0;
		endcase
	end

	assign report.valid          = out_valid_q;
	assign report.clock_line     = (phase_q != gpsph_pkg::PH_LOW);
	assign report.command_line   = (phase_q == gpsph_pkg::PH_LOW || phase_q == gpsph_pkg::PH_HIGH)
		? cmd_byte[bit_q] : 1'b1;
	assign report.attention_line = (phase_q == gpsph_pkg::PH_IDLE);
	assign report.report_valid   = rvalid_q;
	assign report.connected      = link_q;
	assign report.pad_mode       = mode_q;
	assign report.buttons        = btn_q;
	assign report.right_stick_x  = stick_q[0];
	assign report.right_stick_y  = stick_q[1];
	assign report.left_stick_x   = stick_q[2];
	assign report.left_stick_y   = stick_q[3];

endmodule

`default_nettype wire
